// ===== rtl/ltp_pkg.sv =====
// Package for the timestamp parser: widths, character codes, state and
// command types shared by the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package ltp_pkg;

    localparam int CHAR_WIDTH     = 8;
    localparam int TIME_WIDTH     = 38;
    localparam int PART_WIDTH_DEF = 16;
    localparam int NUM_PARTS      = 3;
    localparam int SEC_PER_MIN    = 60;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL0,
        OP_MUL1,
        OP_SCALE
    } acc_op_t;

    typedef struct packed {
        logic    take_char;
        acc_op_t acc_op;
        logic    finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hms_form;
    } dp_status_t;

endpackage

// ===== rtl/ltp_if.sv =====
// Valid/ready stream interfaces for the character words in and the result
// words out. Depends on ltp_pkg.
`timescale 1ns / 1ps

interface ltp_in_if;
    logic                           valid;
    logic                           ready;
    logic [ltp_pkg::CHAR_WIDTH-1:0] char_code;
    logic                           last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ltp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           valid_res;
    logic [ltp_pkg::TIME_WIDTH-1:0] time_ms;

    modport source (output valid, output valid_res, output time_ms, input ready);
    modport sink   (input valid, input valid_res, input time_ms, output ready);
endinterface

// ===== rtl/ltp_datapath.sv =====
// Datapath of the timestamp parser: character scanner, part accumulators,
// a shared shift-add accumulator for the final time and the result register.
// Depends on ltp_pkg.
`timescale 1ns / 1ps

module ltp_datapath #(
    parameter int PART_WIDTH = ltp_pkg::PART_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ltp_pkg::ctrl_cmd_t             cmd,
    input  logic [ltp_pkg::CHAR_WIDTH-1:0] char_code,
    output ltp_pkg::dp_status_t            status,
    output logic                           valid_res,
    output logic [ltp_pkg::TIME_WIDTH-1:0] time_ms
);

    localparam int AW = PART_WIDTH + 31;
    localparam int TW = ltp_pkg::TIME_WIDTH;
    localparam logic [PART_WIDTH-1:0] PART_MAX = {PART_WIDTH{1'b1}};

    logic [PART_WIDTH-1:0] part_reg [ltp_pkg::NUM_PARTS];
    logic [PART_WIDTH-1:0] part_next [ltp_pkg::NUM_PARTS];
    logic [1:0]            sep_reg, sep_next;
    logic [9:0]            frac_reg, frac_next;
    logic [1:0]            fdig_reg, fdig_next;
    logic                  infrac_reg, infrac_next;
    logic                  err_reg, err_next;
    logic                  start_reg, start_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic                  valid_res_reg, valid_res_next;
    logic [TW-1:0]         time_reg, time_next;

    logic                  is_digit;
    logic [3:0]            dval;
    logic                  eff_err;
    logic [1:0]            pidx;
    logic [PART_WIDTH+3:0] part_sum;
    logic [AW-1:0]         p0_e, p1_e, p2_e, frac_e;
    logic                  hms, ok;

    assign is_digit = (char_code >= ltp_pkg::CH_ZERO) && (char_code <= ltp_pkg::CH_NINE);
    assign dval     = 4'(char_code - ltp_pkg::CH_ZERO);
    assign eff_err  = err_reg || (start_reg && !is_digit);
    assign pidx     = (sep_reg > 2'd2) ? 2'd2 : sep_reg;
    // Times ten as two shifts, then saturate the part.
    assign part_sum = ({4'b0, part_reg[pidx]} << 3) + ({4'b0, part_reg[pidx]} << 1)
                      + (PART_WIDTH+4)'(dval);

    assign p0_e = AW'(part_reg[0]);
    assign p1_e = AW'(part_reg[1]);
    assign p2_e = AW'(part_reg[2]);
    assign hms  = (sep_reg == 2'd2) && infrac_reg;
    assign ok   = !err_reg && (sep_reg != 2'd0)
                  && (hms || (part_reg[1] < PART_WIDTH'(ltp_pkg::SEC_PER_MIN)));

    assign status.hms_form = hms;

    // Fraction brought to milliseconds. Two colons without a dot make the
    // third part centiseconds.
    always_comb
    begin
        if ((sep_reg == 2'd2) && !infrac_reg)
        begin
            frac_e = (p2_e << 3) + (p2_e << 1);
        end
        else
        begin
            unique case (fdig_reg)
                2'd0: frac_e = AW'(0);
                2'd1: frac_e = (AW'(frac_reg) << 6) + (AW'(frac_reg) << 5)
                               + (AW'(frac_reg) << 2);
                2'd2: frac_e = (AW'(frac_reg) << 3) + (AW'(frac_reg) << 1);
                default: frac_e = AW'(frac_reg);
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < ltp_pkg::NUM_PARTS; i++)
        begin
            part_next[i] = part_reg[i];
        end
        sep_next    = sep_reg;
        frac_next   = frac_reg;
        fdig_next   = fdig_reg;
        infrac_next = infrac_reg;
        err_next    = err_reg;
        start_next  = start_reg;

        if (cmd.take_char)
        begin
            start_next = 1'b0;
            err_next   = eff_err;
            if (!eff_err)
            begin
                priority if (is_digit)
                begin
                    if (infrac_reg)
                    begin
                        if (fdig_reg != 2'd3)
                        begin
                            frac_next = 10'((frac_reg << 3) + (frac_reg << 1)) + 10'(dval);
                            fdig_next = fdig_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        part_next[pidx] = (part_sum > (PART_WIDTH+4)'(PART_MAX))
                                          ? PART_MAX : part_sum[PART_WIDTH-1:0];
                    end
                end
                else if ((char_code == ltp_pkg::CH_COLON) && !infrac_reg)
                begin
                    if (sep_reg >= 2'd2)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        sep_next = sep_reg + 2'd1;
                    end
                end
                else if ((char_code == ltp_pkg::CH_DOT) && !infrac_reg)
                begin
                    infrac_next = 1'b1;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end

        if (cmd.finish)
        begin
            for (int i = 0; i < ltp_pkg::NUM_PARTS; i++)
            begin
                part_next[i] = '0;
            end
            sep_next    = '0;
            frac_next   = '0;
            fdig_next   = '0;
            infrac_next = 1'b0;
            err_next    = 1'b0;
            start_next  = 1'b1;
        end
    end

    // Times 60 is (x << 6) - (x << 2); times 1000 is (x << 10) - (x << 4) - (x << 3).
    always_comb
    begin
        unique case (cmd.acc_op)
            ltp_pkg::OP_MUL0:  acc_next = (p0_e << 6) - (p0_e << 2) + p1_e;
            ltp_pkg::OP_MUL1:  acc_next = (acc_reg << 6) - (acc_reg << 2) + p2_e;
            ltp_pkg::OP_SCALE: acc_next = (acc_reg << 10) - (acc_reg << 4) - (acc_reg << 3)
                                          + frac_e;
            default:           acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        valid_res_next = valid_res_reg;
        time_next      = time_reg;
        if (cmd.finish)
        begin
            valid_res_next = ok;
            if (!ok)
            begin
                time_next = '0;
            end
            else if (|acc_reg[AW-1:TW])
            begin
                time_next = {TW{1'b1}};
            end
            else
            begin
                time_next = acc_reg[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ltp_pkg::NUM_PARTS; i++)
            begin
                part_reg[i] <= '0;
            end
            sep_reg    <= '0;
            frac_reg   <= '0;
            fdig_reg   <= '0;
            infrac_reg <= 1'b0;
            err_reg    <= 1'b0;
            start_reg  <= 1'b1;
        end
        else
        begin
            for (int i = 0; i < ltp_pkg::NUM_PARTS; i++)
            begin
                part_reg[i] <= part_next[i];
            end
            sep_reg    <= sep_next;
            frac_reg   <= frac_next;
            fdig_reg   <= fdig_next;
            infrac_reg <= infrac_next;
            err_reg    <= err_next;
            start_reg  <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        valid_res_reg <= valid_res_next;
        time_reg      <= time_next;
    end

    assign valid_res = valid_res_reg;
    assign time_ms   = time_reg;

endmodule

// ===== rtl/ltp_ctrl.sv =====
// Controller of the timestamp parser: sequences character intake, the three
// accumulate steps of the final time (the second only for h:mm:ss.f) and the output handshake.
// Depends on ltp_pkg.
`timescale 1ns / 1ps

module ltp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ltp_pkg::dp_status_t status,
    output ltp_pkg::ctrl_cmd_t  cmd
);

    ltp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.take_char  = 1'b0;
        cmd.acc_op     = ltp_pkg::OP_NONE;
        cmd.finish     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ltp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_char = 1'b1;
                    if (in_last)
                    begin
                        state_next = ltp_pkg::ST_MUL0;
                    end
                end
            end
            ltp_pkg::ST_MUL0:
            begin
                cmd.acc_op = ltp_pkg::OP_MUL0;
                state_next = status.hms_form ? ltp_pkg::ST_MUL1 : ltp_pkg::ST_SCALE;
            end
            ltp_pkg::ST_MUL1:
            begin
                cmd.acc_op = ltp_pkg::OP_MUL1;
                state_next = ltp_pkg::ST_SCALE;
            end
            ltp_pkg::ST_SCALE:
            begin
                cmd.acc_op = ltp_pkg::OP_SCALE;
                state_next = ltp_pkg::ST_DONE;
            end
            ltp_pkg::ST_DONE:
            begin
                // The result register is free once the previous word is taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ltp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ltp_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/lrc_timestamp_parser_core.sv =====
// Timestamp parser: one character word per cycle while idle. A word flagged last
// holds the input while the shared shift-add accumulator forms the time in the
// steps MUL0, MUL1 (h:mm:ss.f only) and SCALE; DONE then registers its result word.
// The result sits in an output register and characters are taken while it
// waits; a stalled result delays the result of the next last word. Reset (rst_n low,
// asynchronous) clears the field state. Uses ltp_pkg, ltp_if, ltp_ctrl, ltp_datapath.
`timescale 1ns / 1ps

module lrc_timestamp_parser_core #(
    parameter int PART_WIDTH = ltp_pkg::PART_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ltp_in_if.sink    in_ch,
    ltp_out_if.source out_ch
);

    ltp_pkg::ctrl_cmd_t  cmd;
    ltp_pkg::dp_status_t status;

    ltp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ltp_datapath #(
        .PART_WIDTH (PART_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_code (in_ch.char_code),
        .status    (status),
        .valid_res (out_ch.valid_res),
        .time_ms   (out_ch.time_ms)
    );

endmodule

// ===== rtl/ltp_checker.sv =====
// Port-level checks for the timestamp parser, bound to the top level.
// Depends on ltp_pkg and lrc_timestamp_parser_core.
`timescale 1ns / 1ps

module ltp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           in_last,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           valid_res,
    input logic [ltp_pkg::TIME_WIDTH-1:0] time_ms
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(valid_res) && $stable(time_ms))
        else $error("result word changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> time_ms == '0)
        else $error("rejected field carries a nonzero time");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input taken while the final time is computed");

endmodule

bind lrc_timestamp_parser_core ltp_checker u_ltp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .valid_res (out_ch.valid_res),
    .time_ms   (out_ch.time_ms)
);
